>>> rtl/ilse_pkg.sv
// Shared types, widths and opcodes of the indexed list shift engine.
package ilse_pkg;

  localparam int DEPTH_DEFAULT = 128;
  localparam int DATA_W = 32;
  localparam int POS_W = 7;
  localparam int CNT_W = 8;
  localparam int OPC_W = 3;

  localparam logic [OPC_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OPC_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OPC_W-1:0] OP_GET    = 3'd2;
  localparam logic [OPC_W-1:0] OP_LOCATE = 3'd3;
  localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd4;

  typedef struct packed {
    logic [OPC_W-1:0]   opcode;
    logic [POS_W-1:0]   position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic               status;
    logic signed [DATA_W-1:0] element;
    logic               found;
    logic [POS_W-1:0]   found_position;
    logic [CNT_W-1:0]   count;
    logic               empty_res;
  } rsp_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic               ins;
    logic               del;
    logic               match_pos;
    logic [POS_W-1:0]   pos;
    logic [DATA_W-1:0]  value;
  } cell_ctrl_t;

  // Search wave handed from cell to cell.
  typedef struct packed {
    logic               active;
    logic               hit;
    logic [POS_W-1:0]   idx;
    logic [DATA_W-1:0]  data;
  } scan_t;

endpackage

>>> rtl/ilse_cell.sv
// One list cell: holds an element, shifts with its neighbors, matches the search wave.
module ilse_cell #(
  parameter int DEPTH = ilse_pkg::DEPTH_DEFAULT,
  parameter int CELL_INDEX = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ilse_pkg::cell_ctrl_t        ctrl,
  input  logic [$clog2(DEPTH+1)-1:0]  len,
  input  logic [ilse_pkg::DATA_W-1:0] left_data,
  input  logic [ilse_pkg::DATA_W-1:0] right_data,
  output logic [ilse_pkg::DATA_W-1:0] data,
  input  ilse_pkg::scan_t             scan_in,
  output ilse_pkg::scan_t             scan_out
);
  import ilse_pkg::*;

  localparam int LW = $clog2(DEPTH + 1);
  localparam int W = (LW > POS_W + 1) ? LW : POS_W + 1;
  localparam logic [W-1:0] MY_IDX = W'(CELL_INDEX);

  logic [W-1:0] pos_w;
  logic [W-1:0] len_w;
  logic         match;

  assign pos_w = W'(ctrl.pos);
  assign len_w = W'(len);
  assign match = ctrl.match_pos ? (MY_IDX == pos_w)
                                : ((MY_IDX < len_w) && (data == ctrl.value));

  // Insert pulls from the left, delete pulls from the right.
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (MY_IDX == pos_w) begin
        data <= ctrl.value;
      end else if (MY_IDX > pos_w) begin
        data <= left_data;
      end
    end else if (ctrl.del && (MY_IDX >= pos_w)) begin
      data <= right_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.active <= 1'b0;
    end else begin
      scan_out.active <= scan_in.active;
      if (scan_in.active && !scan_in.hit && match) begin
        scan_out.hit  <= 1'b1;
        scan_out.idx  <= POS_W'(CELL_INDEX);
        scan_out.data <= data;
      end else begin
        scan_out.hit  <= scan_in.hit;
        scan_out.idx  <= scan_in.idx;
        scan_out.data <= scan_in.data;
      end
    end
  end

endmodule

>>> rtl/indexed_list_shift_engine_core.sv
// Indexed list shift engine: request decode, cell chain and result register.
// Insert, clear and rejected requests: the result goes to pend, then to the output
// register in FINISH once that is free. Get, delete and locate: the result is taken
// into pend from the search wave once it has walked the cell chain one cell per cycle.
// One request in flight: a new request is taken only once the last is back in IDLE.
// Reset empties the list (length zero); cell contents are left as they are.
module indexed_list_shift_engine_core #(
  parameter int DEPTH = ilse_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ilse_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ilse_pkg::rsp_t rsp
);
  import ilse_pkg::*;

  localparam int LW = $clog2(DEPTH + 1);
  localparam int W = (LW > POS_W + 1) ? LW : POS_W + 1;

  typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_t;

  state_t           state;
  logic [LW-1:0]    len;
  logic [OPC_W-1:0] req_op;
  logic [POS_W-1:0] req_pos;
  logic [DATA_W-1:0] req_val;
  logic             start;
  rsp_t             pend;

  logic [DATA_W-1:0] cell_data [DEPTH];
  scan_t             scan_chain [DEPTH];
  logic [DEPTH-1:0]  wave_active;
  scan_t             scan_start;
  scan_t             last;
  cell_ctrl_t        ctrl;

  logic          accept;
  logic [W-1:0]  pos_w;
  logic [W-1:0]  len_w;
  logic          ins_ok;
  logic          rd_ok;
  logic          ins_go;
  logic          del_go;
  logic          need_scan;
  logic [LW-1:0] len_imm;
  rsp_t          imm_rsp;
  logic [LW-1:0] len_scan;
  rsp_t          scan_rsp;

  assign req_ready = (state == IDLE);
  assign accept = req_valid && req_ready;
  assign pos_w = W'(req.position);
  assign len_w = W'(len);
  assign ins_ok = (pos_w <= len_w) && (len_w < W'(DEPTH));
  assign rd_ok = (pos_w < len_w);
  assign last = scan_chain[DEPTH-1];

  always_comb begin
    need_scan = 1'b0;
    len_imm = len;
    imm_rsp = '0;
    case (req.opcode)
      OP_INSERT: begin
        if (ins_ok) begin
          len_imm = len + LW'(1);
        end else begin
          imm_rsp.status = 1'b1;
        end
      end
      OP_DELETE, OP_GET: begin
        if (rd_ok) begin
          need_scan = 1'b1;
        end else begin
          imm_rsp.status = 1'b1;
        end
      end
      OP_LOCATE: need_scan = 1'b1;
      OP_CLEAR: len_imm = '0;
      default: imm_rsp.status = 1'b1;
    endcase
    imm_rsp.count = CNT_W'(len_imm);
    imm_rsp.empty_res = (len_imm == '0);
  end

  assign ins_go = accept && (req.opcode == OP_INSERT) && ins_ok;
  assign del_go = (state == SCAN) && last.active && (req_op == OP_DELETE);

  always_comb begin
    scan_rsp = '0;
    len_scan = len;
    if (req_op == OP_LOCATE) begin
      scan_rsp.found = last.hit;
      scan_rsp.found_position = last.hit ? last.idx : '0;
    end else begin
      scan_rsp.element = last.data;
      if (req_op == OP_DELETE) begin
        len_scan = len - LW'(1);
      end
    end
    scan_rsp.count = CNT_W'(len_scan);
    scan_rsp.empty_res = (len_scan == '0);
  end

  always_comb begin
    ctrl.ins = ins_go;
    ctrl.del = del_go;
    ctrl.match_pos = (req_op != OP_LOCATE);
    ctrl.pos = ins_go ? req.position : req_pos;
    ctrl.value = ins_go ? req.value : req_val;
  end

  always_comb begin
    scan_start = '0;
    scan_start.active = start;
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_W-1:0] left_d;
      logic [DATA_W-1:0] right_d;
      scan_t             s_in;
      if (gi == 0) begin : g_first
        assign left_d = '0;
        assign s_in = scan_start;
      end else begin : g_mid
        assign left_d = cell_data[gi-1];
        assign s_in = scan_chain[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_d = '0;
      end else begin : g_inner
        assign right_d = cell_data[gi+1];
      end
      assign wave_active[gi] = scan_chain[gi].active;
      ilse_cell #(
        .DEPTH(DEPTH),
        .CELL_INDEX(gi)
      ) u_cell (
        .clk(clk),
        .rst(rst),
        .ctrl(ctrl),
        .len(len),
        .left_data(left_d),
        .right_data(right_d),
        .data(cell_data[gi]),
        .scan_in(s_in),
        .scan_out(scan_chain[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      len <= '0;
      start <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      start <= 1'b0;
      if (rsp_ready && (state != FINISH)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            req_op <= req.opcode;
            req_pos <= req.position;
            req_val <= req.value;
            if (need_scan) begin
              start <= 1'b1;
              state <= SCAN;
            end else begin
              len <= len_imm;
              pend <= imm_rsp;
              state <= FINISH;
            end
          end
        end
        SCAN: begin
          if (last.active) begin
            len <= len_scan;
            pend <= scan_rsp;
            state <= FINISH;
          end
        end
        FINISH: begin
          // hold the result until the output register is free
          if (!rsp_valid || rsp_ready) begin
            rsp <= pend;
            rsp_valid <= 1'b1;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(DEPTH))
    else $error("list length above depth");

  a_wave_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0({wave_active, start}))
    else $error("more than one search wave in the chain");

  a_wave_in_scan: assert property (@(posedge clk) disable iff (rst)
    last.active |-> (state == SCAN))
    else $error("search wave finished outside a scan");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ins_go |=> (len == $past(len) + LW'(1)))
    else $error("accepted insert did not grow the list");

endmodule
